### rtl/downward_expander_gain_macros.svh
// Assertion macros shared by the downward expander files.
`ifndef DOWNWARD_EXPANDER_GAIN_MACROS_SVH
`define DOWNWARD_EXPANDER_GAIN_MACROS_SVH

// Check cons in the same cycle as ante.
`define DGE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define DGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dge_pkg.sv
// Types and constants shared by the downward expander modules.
package dge_pkg;

  localparam int unsigned COEF_W = 25;
  localparam int unsigned THR_W  = 24;
  localparam int unsigned INV_W  = 44;
  localparam int unsigned POW_W  = 4;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 6;

  localparam logic [23:0]       ONE_Q23 = 24'h800000;
  localparam logic [COEF_W-1:0] ONE_Q24 = 25'h1000000;

  typedef enum logic [2:0] {
    REG_ATTACK,
    REG_RELEASE,
    REG_THRESH,
    REG_THRINV,
    REG_POWER,
    REG_FRAC,
    REG_ENABLE
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [THR_W-1:0]  thr;
    logic [INV_W-1:0]  inv;
    logic [POW_W-1:0]  power;
    logic [FRAC_W-1:0] frac;
    logic              on;
  } cfg_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_STEP,
    MUL_UHI,
    MUL_ULO,
    MUL_POW,
    MUL_BLEND,
    MUL_GAIN,
    MUL_SCALE
  } mul_sel_t;

  // Register update performed by the datapath this cycle.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_ENV,
    ACT_ACC,
    ACT_U,
    ACT_P,
    ACT_B,
    ACT_G,
    ACT_RES_MAG,
    ACT_RES_MUL,
    ACT_OUT
  } act_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
  } dp_stat_t;

endpackage

### rtl/downward_expander_gain.sv
// Top level of the downward expander: register bank, controller and datapath.
//
// Each sample word is scaled by a downward-expander gain derived from an envelope
// follower. All products go in turn through one max(SAMPLE_BITS, 24) x 25 multiplier,
// so the time from accepting a word to presenting its result is set by the
// controller's walk through that multiplier: with the expander off, or on with the
// updated envelope at or above the threshold, the magnitude passes to the output;
// below the threshold the ratio, min(gain_power, MAX_POWER) power steps (one multiply
// a cycle), the blend, the gain and the scale follow. The next word is taken in the
// cycle after the result enters the output register, while that result may still wait
// there. Register writes take effect at once and need no setup pass after reset.
`include "downward_expander_gain_macros.svh"

module downward_expander_gain #(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_POWER   = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dge_pkg::ADDR_W-1:0]    paddr,
  input  logic [dge_pkg::DATA_W-1:0]    pwdata,
  output logic [dge_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import dge_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  dge_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dge_ctrl #(
    .MAX_POWER (MAX_POWER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg       (cfg),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  dge_datapath #(
    .SB (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_sample_in),
    .cfg        (cfg),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .out_sample (out_sample_out)
  );

  // Checks on the sequencing
  `DGE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept left idle")
  `DGE_ASSERT_SAME(a_mul_only_busy, dp_cmd.mul_sel != MUL_NONE, in_stall, "multiply while idle")
  `DGE_ASSERT_SAME(a_out_load_free, dp_cmd.act == ACT_OUT, !out_valid || !out_stall, "output lost")

endmodule

### rtl/dge_regs.sv
// Configuration register bank behind the APB-style port.
module dge_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dge_pkg::ADDR_W-1:0] paddr,
  input  logic [dge_pkg::DATA_W-1:0] pwdata,
  output logic [dge_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dge_pkg::cfg_t              cfg
);
  import dge_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ATTACK:  cfg_nxt.attack_coef  = pwdata[COEF_W-1:0];
        REG_RELEASE: cfg_nxt.release_coef = pwdata[COEF_W-1:0];
        REG_THRESH:  cfg_nxt.thr          = pwdata[THR_W-1:0];
        REG_THRINV:  cfg_nxt.inv          = pwdata[INV_W-1:0];
        REG_POWER:   cfg_nxt.power        = pwdata[POW_W-1:0];
        REG_FRAC:    cfg_nxt.frac         = pwdata[FRAC_W-1:0];
        REG_ENABLE:  cfg_nxt.on           = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_ATTACK:  prdata = DATA_W'(cfg_r.attack_coef);
      REG_RELEASE: prdata = DATA_W'(cfg_r.release_coef);
      REG_THRESH:  prdata = DATA_W'(cfg_r.thr);
      REG_THRINV:  prdata = DATA_W'(cfg_r.inv);
      REG_POWER:   prdata = DATA_W'(cfg_r.power);
      REG_FRAC:    prdata = DATA_W'(cfg_r.frac);
      REG_ENABLE:  prdata = DATA_W'(cfg_r.on);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef  <= ONE_Q24;
      cfg_r.release_coef <= ONE_Q24;
      cfg_r.thr          <= 24'd8192;
      cfg_r.inv          <= 44'h200000000;
      cfg_r.power        <= 4'd1;
      cfg_r.frac         <= '0;
      cfg_r.on           <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/dge_datapath.sv
// Datapath: envelope, shared multiplier and the gain chain registers.
module dge_datapath #(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [SB-1:0] in_sample,
  input  dge_pkg::cfg_t        cfg,
  input  dge_pkg::dp_cmd_t     cmd,
  output dge_pkg::dp_stat_t    stat,
  output logic signed [SB-1:0] out_sample
);
  import dge_pkg::*;

  localparam int AW = (SB > 24) ? SB : 24;
  localparam int BW = 25;
  localparam int PW = AW + BW;

  logic [SB-1:0]     mag_r, env_r, res_r, out_r;
  logic              neg_r;
  logic [PW-1:0]     prod_r, acc_r;
  logic [23:0]       u_r, p_r, b_r, g_r;

  logic [SB-1:0]     raw, mag_in, diff, step;
  logic              up;
  logic [COEF_W-1:0] coef, coef_sat;
  logic [AW-1:0]     mul_a;
  logic [BW-1:0]     mul_b;
  logic [PW-1:0]     product;
  logic [PW:0]       usum;
  logic [23:0]       u_new, g_new;
  logic [16:0]       blend_k;
  logic [40:0]       bsum;
  logic [PW-24:0]    gq;

  // Sample magnitude; the most negative code maps to 2^(SB-1)
  assign raw    = in_sample;
  assign mag_in = raw[SB-1] ? (~raw + 1'b1) : raw;

  // Envelope step operands
  assign up       = mag_r > env_r;
  assign diff     = up ? (mag_r - env_r) : (env_r - mag_r);
  assign coef     = up ? cfg.attack_coef : cfg.release_coef;
  assign coef_sat = (coef > ONE_Q24) ? ONE_Q24 : coef;
  assign step     = prod_r[SB+23:24];

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP:  begin mul_a = AW'(diff);  mul_b = coef_sat;              end
      MUL_UHI:   begin mul_a = AW'(env_r); mul_b = BW'(cfg.inv[43:23]);   end
      MUL_ULO:   begin mul_a = AW'(env_r); mul_b = BW'(cfg.inv[22:0]);    end
      MUL_POW:   begin mul_a = AW'(p_r);   mul_b = BW'(u_r);              end
      MUL_BLEND: begin mul_a = AW'(u_r);   mul_b = BW'(cfg.frac);         end
      MUL_GAIN:  begin mul_a = AW'(p_r);   mul_b = BW'(b_r);              end
      MUL_SCALE: begin mul_a = AW'(mag_r); mul_b = BW'(g_r);              end
      default:   begin mul_a = '0;         mul_b = '0;                    end
    endcase
  end

  assign product = PW'(mul_a) * PW'(mul_b);

  // Ratio to threshold, saturated to one
  assign usum  = (PW+1)'(acc_r) + (PW+1)'(prod_r >> 23);
  assign u_new = (usum > (PW+1)'(ONE_Q23)) ? ONE_Q23 : usum[23:0];

  // Linear blend term
  assign blend_k = 17'h10000 - 17'(cfg.frac);
  assign bsum    = 41'({blend_k, 23'b0}) + 41'(prod_r[39:0]);

  // Gain, clamped to one
  assign gq    = product[PW-1:23];
  assign g_new = (gq > (PW-23)'(ONE_Q23)) ? ONE_Q23 : gq[23:0];

  assign stat.below = AW'(env_r) < AW'(cfg.thr);
  assign out_sample = out_r;

  // Envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (cmd.act == ACT_ENV) begin
      env_r <= up ? (env_r + step) : (env_r - step);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= product;
    end
    case (cmd.act)
      ACT_LOAD: begin
        mag_r <= mag_in;
        neg_r <= raw[SB-1];
      end
      ACT_ACC:     acc_r <= prod_r;
      ACT_U: begin
        u_r <= u_new;
        p_r <= ONE_Q23;
      end
      ACT_P:       p_r   <= product[46:23];
      ACT_B:       b_r   <= bsum[39:16];
      ACT_G:       g_r   <= g_new;
      ACT_RES_MAG: res_r <= mag_r;
      ACT_RES_MUL: res_r <= product[SB+22:23];
      ACT_OUT:     out_r <= neg_r ? (~res_r + 1'b1) : res_r;
      default: ;
    endcase
  end

endmodule

### rtl/dge_ctrl.sv
// Controller: sequences one sample through the shared multiplier.
module dge_ctrl #(
  parameter int MAX_POWER = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dge_pkg::cfg_t     cfg,
  input  dge_pkg::dp_stat_t stat,
  output dge_pkg::dp_cmd_t  cmd
);
  import dge_pkg::*;

  localparam int CW = $clog2(MAX_POWER + 1);
  localparam logic [POW_W-1:0] PMAX = POW_W'(MAX_POWER);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_ENV,
    S_ENVU,
    S_CMP,
    S_UHI,
    S_ULO,
    S_USUM,
    S_POW,
    S_BLEND,
    S_BADD,
    S_GAIN,
    S_SCALE,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POW_W-1:0] pw;

  assign pw        = (cfg.power > PMAX) ? PMAX : cfg.power;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath command
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.mul_sel = MUL_NONE;
    cmd.act     = ACT_NONE;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = cfg.on ? S_ENV : S_PASS;
        end
      end
      S_PASS: begin
        cmd.act   = ACT_RES_MAG;
        state_nxt = S_OUT;
      end
      S_ENV: begin
        cmd.mul_sel = MUL_STEP;
        state_nxt   = S_ENVU;
      end
      S_ENVU: begin
        cmd.act   = ACT_ENV;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.below) begin
          state_nxt = S_UHI;
        end else begin
          cmd.act   = ACT_RES_MAG;
          state_nxt = S_OUT;
        end
      end
      S_UHI: begin
        cmd.mul_sel = MUL_UHI;
        state_nxt   = S_ULO;
      end
      S_ULO: begin
        cmd.mul_sel = MUL_ULO;
        cmd.act     = ACT_ACC;
        state_nxt   = S_USUM;
      end
      S_USUM: begin
        cmd.act   = ACT_U;
        cnt_nxt   = pw[CW-1:0];
        state_nxt = (pw == '0) ? S_BLEND : S_POW;
      end
      S_POW: begin
        cmd.mul_sel = MUL_POW;
        cmd.act     = ACT_P;
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.mul_sel = MUL_BLEND;
        state_nxt   = S_BADD;
      end
      S_BADD: begin
        cmd.act   = ACT_B;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.mul_sel = MUL_GAIN;
        cmd.act     = ACT_G;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_sel = MUL_SCALE;
        cmd.act     = ACT_RES_MUL;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // Load the output word once the register is free or draining
        if (!out_valid_r || !out_stall) begin
          cmd.act       = ACT_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
